@@ rtl/kufef_pkg.sv @@
// Package for the Kruskal union-find edge filter.
// Holds item and result types, controller/datapath interface structs and codes.
// No dependencies.
`default_nettype none

package kufef_pkg;

  // Field widths of the item format and the configuration interface
  localparam int END_W     = 9;
  localparam int WEIGHT_W  = 32;
  localparam int CNT_W     = 10;
  localparam int CFG_IDX_W = 2;

  // Default parent table depth
  localparam int MAX_POINTS_DEF = 512;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_COUNT   = 2'd1;
  localparam logic [CNT_W-1:0]     POINT_COUNT_RST = 10'd512;
  localparam logic [CNT_W-1:0]     SAT_COUNT_RST   = 10'd1;

  // Input item: one edge
  typedef struct packed {
    logic                new_case;
    logic [END_W-1:0]    end_a;
    logic [END_W-1:0]    end_b;
    logic [WEIGHT_W-1:0] weight;
  } item_t;

  // Result item
  typedef struct packed {
    logic                accepted;
    logic                tree_done;
    logic                answer_valid;
    logic [WEIGHT_W-1:0] answer_weight;
  } result_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_FIND_A,
    ST_COMP_A,
    ST_FIND_B,
    ST_COMP_B,
    ST_LINK
  } state_e;

  // Datapath pointer / memory operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_STEP,
    OP_STEP_WR,
    OP_CLEAR
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    op_e  op;
    logic sel_b;
    logic save_ra;
    logic save_rb;
    logic load_item;
    logic emit;
    logic link;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rdata_is_cur;
    logic cur_is_ra;
    logic cur_is_rb;
    logic in_range;
    logic tree_full;
    logic clr_last;
  } stat_t;

endpackage : kufef_pkg

`default_nettype wire

@@ rtl/kruskal_union_find_edge_filter.sv @@
// Top level of the Kruskal union-find edge filter.
// Uses kufef_pkg, kufef_ctrl, kufef_dp (which holds kufef_ram).
//
//   channel   handshake                      payload
//   edge in   start / busy (take: start&!busy) item_i   (kufef_pkg::item_t)
//   result    res_valid_o, one-cycle strobe  res_o    (kufef_pkg::result_t)
//   config    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each find walk and each compression walk does one parent table read per
// cycle. An edge that comes after tree completion or has an end point out
// of range is not walked; only its result is given. An edge with new_case
// set first rewrites the whole parent table. After reset busy stays high
// while the table is set up. The result strobe follows the last working
// cycle; results cannot be held off.
`default_nettype none

module kruskal_union_find_edge_filter #(
  parameter int MAX_POINTS = kufef_pkg::MAX_POINTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire kufef_pkg::item_t                item_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [kufef_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [kufef_pkg::CNT_W-1:0]     cfg_data_i,
  output logic                                 res_valid_o,
  output kufef_pkg::result_t                   res_o
);

  kufef_pkg::cmd_t  cmd;
  kufef_pkg::stat_t stat;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  kufef_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .new_case_i(item_i.new_case),
    .busy_o    (busy),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  kufef_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .item_i     (item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule : kruskal_union_find_edge_filter

`default_nettype wire

@@ rtl/kufef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module kufef_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : kufef_ram

`default_nettype wire

@@ rtl/kufef_dp.sv @@
// Datapath of the Kruskal edge filter: parent table, find pointer, roots,
// counters, configuration and result registers. Uses kufef_pkg, kufef_ram.
`default_nettype none

module kufef_dp #(
  parameter int MAX_POINTS = kufef_pkg::MAX_POINTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire kufef_pkg::cmd_t                    cmd_i,
  output kufef_pkg::stat_t                        stat_o,
  input  wire kufef_pkg::item_t                   item_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [kufef_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [kufef_pkg::CNT_W-1:0]        cfg_data_i,
  output logic                                    res_valid_o,
  output kufef_pkg::result_t                      res_o
);

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = kufef_pkg::CNT_W;

  kufef_pkg::item_t   item_q;
  kufef_pkg::result_t res_q, res_d;
  logic               res_valid_q;

  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] ra_q, rb_q;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [CntW-1:0] pc_q, sc_q;

  logic [IdxW-1:0] a_idx, b_idx;
  logic [IdxW-1:0] rdata;
  logic [IdxW-1:0] raddr, waddr, wdata;
  logic            we;

  logic [CntW-1:0] target, cnt_inc;
  logic            full, differ, ans_hit, a_ok, b_ok, clr_last;

  assign a_idx = IdxW'(item_q.end_a);
  assign b_idx = IdxW'(item_q.end_b);

  // Case bookkeeping
  assign target   = (pc_q == '0) ? '0 : pc_q - CntW'(1);
  assign full     = done_q || (cnt_q >= target);
  assign differ   = (ra_q != rb_q);
  assign cnt_inc  = cnt_q + CntW'(1);
  assign ans_hit  = (sc_q < pc_q) && (cnt_inc == pc_q - sc_q);
  assign clr_last = (clr_q == IdxW'(MAX_POINTS - 1));

  // End points must be below both point_count and the table depth
  assign a_ok = (CntW'(item_q.end_a) < pc_q) && (32'(item_q.end_a) < 32'(MAX_POINTS));
  assign b_ok = (CntW'(item_q.end_b) < pc_q) && (32'(item_q.end_b) < 32'(MAX_POINTS));

  // Status to controller
  always_comb begin
    stat_o.rdata_is_cur = (rdata == cur_q);
    stat_o.cur_is_ra    = (cur_q == ra_q);
    stat_o.cur_is_rb    = (cur_q == rb_q);
    stat_o.in_range     = a_ok && b_ok;
    stat_o.tree_full    = full;
    stat_o.clr_last     = clr_last;
  end

  // Memory address / write selection and pointer update
  always_comb begin
    raddr = cur_q;
    we    = 1'b0;
    waddr = cur_q;
    wdata = ra_q;
    cur_d = cur_q;
    clr_d = clr_q;
    case (cmd_i.op)
      kufef_pkg::OP_LOAD_A: begin
        raddr = a_idx;
        cur_d = a_idx;
      end
      kufef_pkg::OP_LOAD_B: begin
        raddr = b_idx;
        cur_d = b_idx;
      end
      kufef_pkg::OP_STEP: begin
        raddr = rdata;
        cur_d = rdata;
      end
      kufef_pkg::OP_STEP_WR: begin
        // point this node at its root, move on to its old parent
        raddr = rdata;
        cur_d = rdata;
        we    = 1'b1;
        wdata = cmd_i.sel_b ? rb_q : ra_q;
      end
      kufef_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = clr_q;
        clr_d = clr_last ? '0 : clr_q + IdxW'(1);
      end
      default: begin
      end
    endcase
    // union: hang root of a below root of b
    if (cmd_i.link && differ) begin
      we    = 1'b1;
      waddr = ra_q;
      wdata = rb_q;
    end
  end

  // Counters and result
  always_comb begin
    cnt_d = cnt_q;
    done_d = done_q;
    res_d = res_q;
    if (cmd_i.op == kufef_pkg::OP_CLEAR) begin
      cnt_d  = '0;
      done_d = 1'b0;
    end
    if (cmd_i.emit) begin
      if (cmd_i.link) begin
        if (differ) begin
          cnt_d  = cnt_inc;
          done_d = done_q || (cnt_inc >= target);
        end
        res_d.accepted      = differ;
        res_d.tree_done     = done_d;
        res_d.answer_valid  = differ && ans_hit;
        res_d.answer_weight = (differ && ans_hit) ? item_q.weight : '0;
      end else begin
        done_d              = full;
        res_d.accepted      = 1'b0;
        res_d.tree_done     = full;
        res_d.answer_valid  = 1'b0;
        res_d.answer_weight = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
      pc_q        <= kufef_pkg::POINT_COUNT_RST;
      sc_q        <= kufef_pkg::SAT_COUNT_RST;
    end else begin
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      res_valid_q <= cmd_i.emit;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kufef_pkg::CFG_POINT_COUNT: pc_q <= cfg_data_i;
          kufef_pkg::CFG_SAT_COUNT:   sc_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    if (cmd_i.save_ra) begin
      ra_q <= cur_q;
    end
    if (cmd_i.save_rb) begin
      rb_q <= cur_q;
    end
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  // Parent table
  kufef_ram #(
    .WIDTH(IdxW),
    .DEPTH(MAX_POINTS)
  ) u_parent (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule : kufef_dp

`default_nettype wire

@@ rtl/kufef_ctrl.sv @@
// Controller of the Kruskal edge filter: sequences table clearing, the two
// find-and-compress walks and the union. Uses kufef_pkg.
`default_nettype none

module kufef_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             new_case_i,
  output logic                  busy_o,
  input  wire kufef_pkg::stat_t stat_i,
  output kufef_pkg::cmd_t       cmd_o
);

  kufef_pkg::state_e state_q, state_d;

  // State register; reset starts with a table clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kufef_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.op        = kufef_pkg::OP_NONE;
    cmd_o.sel_b     = 1'b0;
    cmd_o.save_ra   = 1'b0;
    cmd_o.save_rb   = 1'b0;
    cmd_o.load_item = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.link      = 1'b0;
    case (state_q)
      kufef_pkg::ST_INIT: begin
        cmd_o.op = kufef_pkg::OP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = kufef_pkg::ST_IDLE;
        end
      end
      kufef_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d = new_case_i ? kufef_pkg::ST_CLEAR : kufef_pkg::ST_CHECK;
        end
      end
      kufef_pkg::ST_CLEAR: begin
        cmd_o.op = kufef_pkg::OP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = kufef_pkg::ST_CHECK;
        end
      end
      kufef_pkg::ST_CHECK: begin
        if (!stat_i.tree_full && stat_i.in_range) begin
          cmd_o.op = kufef_pkg::OP_LOAD_A;
          state_d  = kufef_pkg::ST_FIND_A;
        end else begin
          // tree complete or end point out of range
          cmd_o.emit = 1'b1;
          state_d    = kufef_pkg::ST_IDLE;
        end
      end
      kufef_pkg::ST_FIND_A: begin
        if (stat_i.rdata_is_cur) begin
          cmd_o.save_ra = 1'b1;
          cmd_o.op      = kufef_pkg::OP_LOAD_A;
          state_d       = kufef_pkg::ST_COMP_A;
        end else begin
          cmd_o.op = kufef_pkg::OP_STEP;
        end
      end
      kufef_pkg::ST_COMP_A: begin
        if (stat_i.cur_is_ra) begin
          cmd_o.op = kufef_pkg::OP_LOAD_B;
          state_d  = kufef_pkg::ST_FIND_B;
        end else begin
          cmd_o.op = kufef_pkg::OP_STEP_WR;
        end
      end
      kufef_pkg::ST_FIND_B: begin
        if (stat_i.rdata_is_cur) begin
          cmd_o.save_rb = 1'b1;
          cmd_o.op      = kufef_pkg::OP_LOAD_B;
          state_d       = kufef_pkg::ST_COMP_B;
        end else begin
          cmd_o.op = kufef_pkg::OP_STEP;
        end
      end
      kufef_pkg::ST_COMP_B: begin
        cmd_o.sel_b = 1'b1;
        if (stat_i.cur_is_rb) begin
          state_d = kufef_pkg::ST_LINK;
        end else begin
          cmd_o.op = kufef_pkg::OP_STEP_WR;
        end
      end
      kufef_pkg::ST_LINK: begin
        cmd_o.link = 1'b1;
        cmd_o.emit = 1'b1;
        state_d    = kufef_pkg::ST_IDLE;
      end
      default: begin
        state_d = kufef_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != kufef_pkg::ST_IDLE);

endmodule : kufef_ctrl

`default_nettype wire

@@ rtl/kufef_chk.sv @@
// Port-level checks for the Kruskal edge filter, bound to the top level.
// Uses kufef_pkg.
`default_nettype none

module kufef_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               busy,
  input wire logic               res_valid_o,
  input wire kufef_pkg::result_t res_o
);

  // A result only follows a cycle of work
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // One result per item: strobes never touch
  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // The selected edge is always an accepted one
  a_answer_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.answer_valid) |-> res_o.accepted)
    else $error("answer on an edge that was not accepted");

  // Weight is zero unless it is the answer
  a_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.answer_valid) |-> (res_o.answer_weight == '0))
    else $error("answer weight set without answer");

endmodule : kufef_chk

bind kruskal_union_find_edge_filter kufef_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

`default_nettype wire
